// ===== hw/rtl/ethernet_ipv4_tcp_header_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Ethernet/IPv4/TCP header parser
// Shared wrappers around clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IPV4_TCP_HEADER_PARSER_ASSERT_SVH
`define ETHERNET_IPV4_TCP_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ETHIP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("header parser assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ETHIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("header parser assertion failed");

`endif

// ===== hw/rtl/ethip_pkg.sv =====
// ----------------------------------------------------------------------------
// ethip_pkg
// Types and constants shared by the header parser modules.
// ----------------------------------------------------------------------------
package ethip_pkg;

    localparam int MAX_FRAME_BYTES = 1518;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] ETH_BYTES     = 7'd14;
    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
    localparam logic [7:0] NIB_LO        = 8'h0f;
    localparam logic [7:0] NIB_HI        = 8'hf0;

    // Frame-relative byte offsets of the fixed IPv4 fields
    localparam logic [6:0] OFS_TOTLEN_HI = 7'd16;
    localparam logic [6:0] OFS_TOTLEN_LO = 7'd17;
    localparam logic [6:0] OFS_PROTO     = 7'd23;
    localparam logic [6:0] OFS_SRC_FIRST = 7'd26;
    localparam logic [6:0] OFS_SRC_LAST  = 7'd29;
    localparam logic [6:0] OFS_DST_FIRST = 7'd30;
    localparam logic [6:0] OFS_DST_LAST  = 7'd33;
    localparam logic [6:0] IP_FIXED_END  = 7'd34;
    localparam logic [6:0] TCP_OFS_BYTE  = 7'd12;
    localparam logic [6:0] TCP_PORT_SPAN = 7'd3;

    localparam logic [7:0] PROTO_IP   = 8'd0;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [2:0] ST_TCP_OK  = 3'd0;
    localparam logic [2:0] ST_BAD_IP  = 3'd1;
    localparam logic [2:0] ST_UDP     = 3'd2;
    localparam logic [2:0] ST_ICMP    = 3'd3;
    localparam logic [2:0] ST_IP      = 3'd4;
    localparam logic [2:0] ST_OTHER   = 3'd5;
    localparam logic [2:0] ST_BAD_TCP = 3'd6;
    localparam logic [2:0] ST_TRUNC   = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] packet_number;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [7:0]  protocol_number;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [5:0]  ip_header_bytes;
        logic [5:0]  tcp_header_bytes;
        logic [7:0]  payload_offset;
        logic [15:0] payload_length;
    } out_item_t;

    // Raw captured header state of one finished frame
    typedef struct packed {
        logic [POS_W-1:0] byte_count;
        logic [3:0]       ip_nib;
        logic [3:0]       tcp_nib;
        logic [15:0]      total_len;
        logic [7:0]       proto;
        logic [31:0]      src;
        logic [31:0]      dst;
        logic [31:0]      ports;
        logic [31:0]      pkt_num;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_stat_t;

endpackage

// ===== hw/rtl/ethip_front.sv =====
// ----------------------------------------------------------------------------
// ethip_front
// Byte-rate field capture; emits one frame record per last byte.
// ----------------------------------------------------------------------------
module ethip_front
    import ethip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  in_item_t   item,
    input  q_stat_t    q_stat,
    output logic       push,
    output frame_rec_t push_rec
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       ip_nib_reg, ip_nib_next;
    logic [3:0]       tcp_nib_reg, tcp_nib_next;
    logic [15:0]      tot_reg, tot_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      src_reg, src_next;
    logic [31:0]      dst_reg, dst_next;
    logic [31:0]      ports_reg, ports_next;
    logic [31:0]      frame_cnt_reg, frame_cnt_next;
    logic [6:0]       tcp_start;
    logic             accept;
    logic [7:0]       b;

    assign item_stall = q_stat.full;
    assign accept     = item_valid && !item_stall;
    assign b          = item.data_byte;
    assign tcp_start  = ETH_BYTES + {1'b0, ip_nib_reg, 2'b00};

    always_comb
    begin
        pos_next     = pos_reg;
        ip_nib_next  = ip_nib_reg;
        tcp_nib_next = tcp_nib_reg;
        tot_next     = tot_reg;
        proto_next   = proto_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        ports_next   = ports_reg;
        // bytes past the size limit are dropped and the position saturates
        if (pos_reg < POS_W'(MAX_FRAME_BYTES))
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(ETH_BYTES))
            begin
                ip_nib_next = b[3:0] & NIB_LO[3:0];
            end
            else if (pos_reg == POS_W'(OFS_TOTLEN_HI) || pos_reg == POS_W'(OFS_TOTLEN_LO))
            begin
                tot_next = {tot_reg[7:0], b};
            end
            else if (pos_reg == POS_W'(OFS_PROTO))
            begin
                proto_next = b;
            end
            else if (pos_reg >= POS_W'(OFS_SRC_FIRST) && pos_reg <= POS_W'(OFS_SRC_LAST))
            begin
                src_next = {src_reg[23:0], b};
            end
            else if (pos_reg >= POS_W'(OFS_DST_FIRST) && pos_reg <= POS_W'(OFS_DST_LAST))
            begin
                dst_next = {dst_reg[23:0], b};
            end
            // TCP window follows the IP header; only once a sane length is known
            if (ip_nib_reg >= MIN_HDR_WORDS && pos_reg > POS_W'(ETH_BYTES))
            begin
                if (pos_reg >= POS_W'(tcp_start)
                    && pos_reg <= POS_W'(tcp_start + TCP_PORT_SPAN))
                begin
                    ports_next = {ports_reg[23:0], b};
                end
                else if (pos_reg == POS_W'(tcp_start + TCP_OFS_BYTE))
                begin
                    tcp_nib_next = 4'((b & NIB_HI) >> 4);
                end
            end
        end
    end

    assign frame_cnt_next = frame_cnt_reg + 32'd1;
    assign push           = accept && item.last_byte;

    always_comb
    begin
        push_rec.byte_count = pos_next;
        push_rec.ip_nib     = ip_nib_next;
        push_rec.tcp_nib    = tcp_nib_next;
        push_rec.total_len  = tot_next;
        push_rec.proto      = proto_next;
        push_rec.src        = src_next;
        push_rec.dst        = dst_next;
        push_rec.ports      = ports_next;
        push_rec.pkt_num    = frame_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ip_nib_reg    <= '0;
            tcp_nib_reg   <= '0;
            tot_reg       <= '0;
            proto_reg     <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            ports_reg     <= '0;
            frame_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (item.last_byte)
            begin
                pos_reg       <= '0;
                ip_nib_reg    <= '0;
                tcp_nib_reg   <= '0;
                tot_reg       <= '0;
                proto_reg     <= '0;
                src_reg       <= '0;
                dst_reg       <= '0;
                ports_reg     <= '0;
                frame_cnt_reg <= frame_cnt_next;
            end
            else
            begin
                pos_reg     <= pos_next;
                ip_nib_reg  <= ip_nib_next;
                tcp_nib_reg <= tcp_nib_next;
                tot_reg     <= tot_next;
                proto_reg   <= proto_next;
                src_reg     <= src_next;
                dst_reg     <= dst_next;
                ports_reg   <= ports_next;
            end
        end
    end

endmodule

// ===== hw/rtl/ethip_queue.sv =====
// ----------------------------------------------------------------------------
// ethip_queue
// Short record queue between the capture front and the result back end.
// ----------------------------------------------------------------------------
module ethip_queue
    import ethip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_rec,
    input  logic       pop,
    output frame_rec_t head_rec,
    output q_stat_t    q_stat
);

    frame_rec_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.avail = (cnt_reg != '0);
    assign head_rec     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/ethip_back.sv =====
// ----------------------------------------------------------------------------
// ethip_back
// Classifies a frame record and holds the result in the output register.
// ----------------------------------------------------------------------------
module ethip_back
    import ethip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  frame_rec_t head_rec,
    input  q_stat_t    q_stat,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_stall,
    output out_item_t  result
);

    out_item_t  res_reg, res_next;
    logic       res_valid_reg;
    logic [5:0] ihl, thl;
    logic [6:0] hdr_sum;
    logic [6:0] tcp_need;

    assign pop = q_stat.avail && (!res_valid_reg || !result_stall);

    assign ihl      = {head_rec.ip_nib, 2'b00};
    assign thl      = {head_rec.tcp_nib, 2'b00};
    assign hdr_sum  = {1'b0, ihl} + {1'b0, thl};
    // TCP data offset byte sits 12 bytes into the TCP header
    assign tcp_need = ETH_BYTES + {1'b0, ihl} + TCP_OFS_BYTE + 7'd1;

    always_comb
    begin
        res_next               = '0;
        res_next.packet_number = head_rec.pkt_num;
        priority if (head_rec.byte_count <= POS_W'(ETH_BYTES))
        begin
            res_next.status = ST_TRUNC;
        end
        else if (head_rec.ip_nib < MIN_HDR_WORDS)
        begin
            res_next.status          = ST_BAD_IP;
            res_next.ip_header_bytes = ihl;
        end
        else if (head_rec.byte_count < POS_W'(IP_FIXED_END))
        begin
            res_next.status = ST_TRUNC;
        end
        else
        begin
            res_next.source_address      = head_rec.src;
            res_next.destination_address = head_rec.dst;
            res_next.protocol_number     = head_rec.proto;
            res_next.ip_header_bytes     = ihl;
            unique case (head_rec.proto)
                PROTO_TCP:
                begin
                    priority if (head_rec.byte_count < POS_W'(tcp_need))
                    begin
                        res_next.status              = ST_TRUNC;
                        res_next.source_address      = '0;
                        res_next.destination_address = '0;
                        res_next.protocol_number     = '0;
                        res_next.ip_header_bytes     = '0;
                    end
                    else if (head_rec.tcp_nib < MIN_HDR_WORDS)
                    begin
                        res_next.status           = ST_BAD_TCP;
                        res_next.tcp_header_bytes = thl;
                    end
                    else
                    begin
                        res_next.status           = ST_TCP_OK;
                        res_next.source_port      = head_rec.ports[31:16];
                        res_next.destination_port = head_rec.ports[15:0];
                        res_next.tcp_header_bytes = thl;
                        res_next.payload_offset   = 8'(ETH_BYTES) + 8'(hdr_sum);
                        res_next.payload_length   = (head_rec.total_len > 16'(hdr_sum))
                                                    ? head_rec.total_len - 16'(hdr_sum)
                                                    : 16'd0;
                    end
                end
                PROTO_UDP:  res_next.status = ST_UDP;
                PROTO_ICMP: res_next.status = ST_ICMP;
                PROTO_IP:   res_next.status = ST_IP;
                default:    res_next.status = ST_OTHER;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== hw/rtl/ethernet_ipv4_tcp_header_parser.sv =====
// ----------------------------------------------------------------------------
// ethernet_ipv4_tcp_header_parser
// Takes one frame byte per transfer and gives one header summary per frame.
// A byte is taken every cycle unless the input stalls; header fields are
// captured at fixed offsets (TCP fields relative to the IPv4 header length)
// as the bytes stream by. The byte marked last pushes the captured fields
// into a two-entry queue; the back end classifies them into the output
// register once they head the queue, if that register is empty or unstalled.
// The input stalls only when the queue is full, which happens only while the
// output stays stalled. Bytes past MAX_FRAME_BYTES are dropped. Status codes:
// 0 TCP ok, 1 bad IP header length, 2 UDP, 3 ICMP, 4 IP, 5 other protocol,
// 6 bad TCP header length, 7 truncated.
// ----------------------------------------------------------------------------
`include "ethernet_ipv4_tcp_header_parser_assert.svh"

module ethernet_ipv4_tcp_header_parser
    import ethip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic       push, pop;
    frame_rec_t push_rec, head_rec;
    q_stat_t    q_stat;

    ethip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_stat     (q_stat),
        .push       (push),
        .push_rec   (push_rec)
    );

    ethip_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_stat   (q_stat)
    );

    ethip_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_rec     (head_rec),
        .q_stat       (q_stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `ETHIP_ASSERT_NOW(a_tcp_ok_offset, result_valid && result.status == ST_TCP_OK,
        result.payload_offset == 8'(ETH_BYTES) + 8'(result.ip_header_bytes)
                                 + 8'(result.tcp_header_bytes))
    `ETHIP_ASSERT_NOW(a_ports_only_tcp_ok, result_valid && result.status != ST_TCP_OK,
        result.source_port == '0 && result.destination_port == '0
        && result.payload_length == '0)
    `ETHIP_ASSERT_NOW(a_trunc_clear, result_valid && result.status == ST_TRUNC,
        result.source_address == '0 && result.ip_header_bytes == '0)
    `ETHIP_ASSERT_NEXT(a_last_reaches_queue,
        item_valid && !item_stall && item.last_byte, q_stat.avail)

endmodule
